// ----- rtl/mcpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mcpf_pkg;

  localparam int unsigned PIPE_COUNT   = 4;
  localparam int unsigned BUFFER_DEPTH = 1024;
  localparam int unsigned REF_MAX      = 255;

  localparam int unsigned IDX_W   = 2;   // pipe_index / new_pipe field width
  localparam int unsigned PIPE_W  = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int unsigned PTR_W   = $clog2(BUFFER_DEPTH);
  localparam int unsigned CNT_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned REF_W   = $clog2(REF_MAX + 1);
  localparam int unsigned ADDR_W  = PIPE_W + PTR_W;
  localparam int unsigned FILL_W  = 11;  // fill_level field width
  localparam int unsigned STORE_DEPTH = PIPE_COUNT * BUFFER_DEPTH;

  typedef enum logic [2:0] {
    CMD_CREATE    = 3'd0,
    CMD_READ      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_CLOSE_RD  = 3'd3,
    CMD_CLOSE_WR  = 3'd4,
    CMD_DUP_RD    = 3'd5,
    CMD_DUP_WR    = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_BLOCK    = 3'd1,
    ST_EOS      = 3'd2,
    ST_NOREADER = 3'd3,
    ST_NOFREE   = 3'd4
  } status_e;

  // Request to the byte store: one write port, one read port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- rtl/mcpf_byte_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcpf_byte_ram (
  input  wire logic              clk_i,
  input  wire mcpf_pkg::ram_req_t req_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [mcpf_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/multi_channel_pipe_fifo_core.sv -----
// Channel   Dir  tuser           tdata (lowest bit up)
// s_axis    in   cmd[2:0]        pipe_index[1:0], data_byte[7:0], zero pad to 16
// m_axis    out  status[2:0]     read_byte[7:0], new_pipe[1:0], fill_level[10:0], pad to 24
//
// One command is taken per transfer; a result is registered and goes out in the
// cycle after the command for all commands but a successful read, which first
// passes through S_READ because the pipe's byte comes from the synchronous byte store.
// Pipe pointers, counts and in-use flags are flip-flops and clear on rst_ni;
// the byte store is not cleared. A waiting result does not block the next
// command as long as it is taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_pipe_fifo_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,   // cmd
  input  wire logic [15:0] s_axis_tdata,   // pipe_index[1:0], data_byte[9:2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [2:0]       m_axis_tuser,   // status
  output logic [23:0]      m_axis_tdata    // read_byte[7:0], new_pipe[9:8], fill[20:10]
);

  localparam int unsigned PC    = mcpf_pkg::PIPE_COUNT;
  localparam int unsigned PTR_W = mcpf_pkg::PTR_W;
  localparam int unsigned CNT_W = mcpf_pkg::CNT_W;
  localparam int unsigned REF_W = mcpf_pkg::REF_W;
  localparam int unsigned PW    = mcpf_pkg::PIPE_W;
  localparam int unsigned IW    = mcpf_pkg::IDX_W;
  localparam int unsigned FW    = mcpf_pkg::FILL_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [PTR_W-1:0] head_q [PC];
  logic [PTR_W-1:0] head_d [PC];
  logic [PTR_W-1:0] tail_q [PC];
  logic [PTR_W-1:0] tail_d [PC];
  logic [CNT_W-1:0] cnt_q  [PC];
  logic [CNT_W-1:0] cnt_d  [PC];
  logic [REF_W-1:0] rdr_q  [PC];
  logic [REF_W-1:0] rdr_d  [PC];
  logic [REF_W-1:0] wtr_q  [PC];
  logic [REF_W-1:0] wtr_d  [PC];
  logic [PC-1:0]    use_q, use_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic [IW-1:0]    out_new_q, out_new_d;
  logic [FW-1:0]    out_fill_q, out_fill_d;

  mcpf_pkg::cmd_e   cmd;
  logic [IW-1:0]    idx;
  logic [7:0]       din;
  logic [PW-1:0]    p;
  logic             in_xfer;
  logic             live;
  logic             rd_ok;
  logic             found;
  logic [PW-1:0]    free_idx;
  mcpf_pkg::status_e status;
  logic [FW-1:0]    fill;
  mcpf_pkg::ram_req_t ram_req;
  logic [7:0]       ram_rdata;

  assign cmd = mcpf_pkg::cmd_e'(s_axis_tuser);
  assign idx = s_axis_tdata[IW-1:0];
  assign din = s_axis_tdata[IW+7:IW];
  assign p   = PW'(idx);

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign live = (32'(idx) < PC) && use_q[p];

  // lowest free pipe
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = PC - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        found    = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    rdr_d   = rdr_q;
    wtr_d   = wtr_q;
    use_d   = use_q;
    status  = mcpf_pkg::ST_DONE;
    rd_ok   = 1'b0;
    ram_req = '0;
    ram_req.waddr = {p, tail_q[p]};
    ram_req.wdata = din;
    ram_req.raddr = {p, head_q[p]};
    fill    = '0;

    if (cmd == mcpf_pkg::CMD_CREATE) begin
      if (found) begin
        head_d[free_idx] = '0;
        tail_d[free_idx] = '0;
        cnt_d[free_idx]  = '0;
        rdr_d[free_idx]  = REF_W'(1);
        wtr_d[free_idx]  = REF_W'(1);
        use_d[free_idx]  = 1'b1;
      end else begin
        status = mcpf_pkg::ST_NOFREE;
      end
    end else if (!live) begin
      if (cmd == mcpf_pkg::CMD_READ) begin
        status = mcpf_pkg::ST_EOS;
      end else if (cmd == mcpf_pkg::CMD_WRITE) begin
        status = mcpf_pkg::ST_NOREADER;
      end
    end else begin
      unique case (cmd)
        mcpf_pkg::CMD_READ: begin
          if (cnt_q[p] != '0) begin
            rd_ok      = 1'b1;
            ram_req.re = 1'b1;
            head_d[p]  = PTR_W'((32'(head_q[p]) + 1) % mcpf_pkg::BUFFER_DEPTH);
            cnt_d[p]   = cnt_q[p] - CNT_W'(1);
          end else begin
            status = (wtr_q[p] == '0) ? mcpf_pkg::ST_EOS : mcpf_pkg::ST_BLOCK;
          end
        end
        mcpf_pkg::CMD_WRITE: begin
          if (32'(cnt_q[p]) < mcpf_pkg::BUFFER_DEPTH) begin
            ram_req.we = 1'b1;
            tail_d[p]  = PTR_W'((32'(tail_q[p]) + 1) % mcpf_pkg::BUFFER_DEPTH);
            cnt_d[p]   = cnt_q[p] + CNT_W'(1);
          end else begin
            status = (rdr_q[p] == '0) ? mcpf_pkg::ST_NOREADER : mcpf_pkg::ST_BLOCK;
          end
        end
        mcpf_pkg::CMD_CLOSE_RD: begin
          if (rdr_q[p] != '0) rdr_d[p] = rdr_q[p] - REF_W'(1);
          if (rdr_d[p] == '0 && wtr_q[p] == '0) use_d[p] = 1'b0;
        end
        mcpf_pkg::CMD_CLOSE_WR: begin
          if (wtr_q[p] != '0) wtr_d[p] = wtr_q[p] - REF_W'(1);
          if (rdr_q[p] == '0 && wtr_d[p] == '0) use_d[p] = 1'b0;
        end
        mcpf_pkg::CMD_DUP_RD: begin
          if (32'(rdr_q[p]) < mcpf_pkg::REF_MAX) rdr_d[p] = rdr_q[p] + REF_W'(1);
        end
        mcpf_pkg::CMD_DUP_WR: begin
          if (32'(wtr_q[p]) < mcpf_pkg::REF_MAX) wtr_d[p] = wtr_q[p] + REF_W'(1);
        end
        default: begin
        end
      endcase
      if (use_d[p]) fill = FW'(cnt_d[p]);
    end

    if (!in_xfer) begin
      ram_req.we = 1'b0;
      ram_req.re = 1'b0;
    end
  end

  mcpf_byte_ram u_store (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register; a successful read fills in its byte from the byte store in S_READ
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_new_d    = out_new_q;
    out_fill_d   = out_fill_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          out_status_d = 3'(status);
          out_byte_d   = '0;
          out_new_d    = (cmd == mcpf_pkg::CMD_CREATE && found) ? IW'(free_idx) : '0;
          out_fill_d   = fill;
          if (rd_ok) begin
            state_d = S_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        out_byte_d  = ram_rdata;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      use_q       <= '0;
      for (int i = 0; i < PC; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
        rdr_q[i]  <= '0;
        wtr_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        use_q  <= use_d;
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
        rdr_q  <= rdr_d;
        wtr_q  <= wtr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_new_q    <= out_new_d;
    out_fill_q   <= out_fill_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_fill_q, out_new_q, out_byte_q};

endmodule

`default_nettype wire

// ----- rtl/mcpf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcpf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic [23:0] m_axis_tdata
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // status codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= mcpf_pkg::ST_NOFREE)
    else $error("undefined status code");

  // only a successful read carries a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != mcpf_pkg::ST_DONE |-> m_axis_tdata[7:0] == 8'd0)
    else $error("byte on failed command");

  // an exhausted pool reports nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == mcpf_pkg::ST_NOFREE |-> m_axis_tdata[20:8] == 13'd0)
    else $error("no-free result carries data");

  // fill level never exceeds the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:10] <= 11'd1024)
    else $error("fill level out of range");

endmodule

bind multi_channel_pipe_fifo_core mcpf_checker u_mcpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
